[rtl/core/gc_pkg.sv]
// Shared widths and constants for the greedy graph colouring block.
package gc_pkg;

   localparam int ROW_W      = 64;  // adjacency row width
   localparam int CFG_W      = 7;   // node count register width
   localparam int NODE_W     = 6;   // node index field width
   localparam int COLOR_W    = 6;   // colour field width
   localparam int RSP_DATA_W = 16;  // node index and colour, padded to whole bytes

   localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

endpackage

[rtl/core/greedy_graph_coloring.sv]
// Top level of the first-fit greedy graph colouring block.
// Rows are taken one at a time: a new row waits until the current result is registered.
// For node k the colour memory read port walks the k earlier neighbours one per cycle (none
// for node 0); a drain state lets the last read land, and the search waits for the output.
// Reset: synchronous; node counter to zero, node count to 64, no result pending.
// The colour memory is not cleared; each entry is written before it is read.
module greedy_graph_coloring
   import gc_pkg::*;
#(
   parameter int MAX_NODES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration: node count
   input  logic                  csr_wr_en,
   input  logic [CFG_W-1:0]      csr_wr_data,
   // Input rows
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ROW_W-1:0]      req_tdata,   // [63:0] adjacency_row
   // Results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] node_index, [11:6] color, [15:12] zero
   output logic                  rsp_tlast    // last_node
);

   // Width of a node index inside the block, and of the used-colour mask.
   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int MASK_W = MAX_NODES;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DRAIN,
      S_SEARCH
   } state_type;

   state_type             state_ff, state_in;
   logic [CFG_W-1:0]      node_count_ff;
   logic [IDX_W-1:0]      next_node_ff, next_node_in;
   logic [IDX_W-1:0]      node_ff, node_in;       // node being coloured
   logic [IDX_W-1:0]      walk_ff, walk_in;       // earlier node being read
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [MASK_W-1:0]     used_ff, used_in;
   logic                  rd_pend_ff, rd_pend_in; // a read is in flight
   logic                  rd_bit_ff, rd_bit_in;   // that neighbour is adjacent
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]     rsp_node_ff, rsp_node_in;
   logic [COLOR_W-1:0]    rsp_color_ff, rsp_color_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [CFG_W-1:0]      count_eff;
   logic [IDX_W-1:0]      start_node;
   logic [COLOR_W-1:0]    rd_color;
   logic [MASK_W-1:0]     free_onehot;
   logic [COLOR_W-1:0]    found_color;
   logic                  is_last;
   logic                  ram_wr_en;
   logic                  slot_free;

   // A count of zero or beyond the storage acts as the full size.
   always_comb begin
      count_eff = node_count_ff;
      if ((node_count_ff == '0) || (node_count_ff > CFG_W'(MAX_NODES))) begin
         count_eff = CFG_W'(MAX_NODES);
      end
   end

   // A stored node counter at or above the count starts a new graph.
   assign start_node = (CFG_W'(next_node_ff) >= count_eff) ? '0 : next_node_ff;

   gc_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (MAX_NODES)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (node_ff),
      .wr_data (found_color),
      .rd_addr (walk_ff),
      .rd_data (rd_color)
   );

   // Lowest clear bit of the used mask, isolated as a one-hot word by the
   // carry of an increment and then encoded. A full mask gives colour zero.
   always_comb begin
      free_onehot = ~used_ff & (used_ff + MASK_W'(1));
      found_color = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (free_onehot[i]) begin
            found_color = found_color | COLOR_W'(i);
         end
      end
   end

   assign is_last   = (CFG_W'(node_ff) == (count_eff - CFG_W'(1)));
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign ram_wr_en = (state_ff == S_SEARCH) && slot_free;

   always_comb begin
      state_in     = state_ff;
      next_node_in = next_node_ff;
      node_in      = node_ff;
      walk_in      = walk_ff;
      row_in       = row_ff;
      used_in      = used_ff;
      rd_pend_in   = 1'b0;
      rd_bit_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_node_in  = rsp_node_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;

      // Fold the colour of the neighbour read in the previous cycle.
      if (rd_pend_ff && rd_bit_ff) begin
         used_in = used_ff | (MASK_W'(1) << rd_color);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               node_in  = start_node;
               row_in   = req_tdata;
               walk_in  = '0;
               used_in  = '0;
               state_in = (start_node == '0) ? S_SEARCH : S_WALK;
            end
         end
         S_WALK: begin
            // walk_ff addresses the memory this cycle; its data lands next cycle.
            rd_pend_in = 1'b1;
            rd_bit_in  = row_ff[walk_ff];
            walk_in    = walk_ff + IDX_W'(1);
            if (walk_ff == (node_ff - IDX_W'(1))) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = NODE_W'(node_ff);
               rsp_color_in = found_color;
               rsp_last_in  = is_last;
               next_node_in = is_last ? '0 : (node_ff + IDX_W'(1));
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= NODE_COUNT_RESET;
         next_node_ff  <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_node_ff <= next_node_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
      end
      node_ff      <= node_in;
      walk_ff      <= walk_in;
      row_ff       <= row_in;
      used_ff      <= used_in;
      rd_bit_ff    <= rd_bit_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // A new row is taken only between items; a finished result may still wait
   // in the output register meanwhile.
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - NODE_W - COLOR_W)'(0), rsp_color_ff, rsp_node_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/core/gc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gc_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
